@@ rtl/core/aarm_pkg.sv @@
// aarm_pkg: item types, datapath widths and constants of the axis-angle rotation block
// no dependencies; used by the interfaces and every core module
`timescale 1ns / 1ps

package aarm_pkg;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               axis_zero;
  } out_item_t;

  // angle to binary angle scale factors
  localparam int                 K_W   = 27;
  localparam logic signed [26:0] RAD_K = 27'sd42722830;
  localparam logic signed [26:0] DEG_K = 27'sd47721859;
  localparam int                 PROD_W = 43;

  // cordic
  localparam int                 XY_W       = 34;
  localparam int                 Z_W        = 33;
  localparam int                 ATAN_COUNT = 24;
  localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;
  localparam int                 ONE_Q30    = 1 << 30;

  // cordic and square root share one pipeline length
  localparam int PIPE_STAGES = 32;

  // divider
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 32;
  localparam int QUO_W   = 34;
  localparam int QS_W    = QUO_W + 1;
  localparam int DIV_LAT = QUO_W + 2;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/aarm_in_if.sv @@
// aarm_in_if: valid/ready channel carrying one input item
// depends on aarm_pkg
`timescale 1ns / 1ps

interface aarm_in_if;
  logic               valid;
  logic               ready;
  aarm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/aarm_out_if.sv @@
// aarm_out_if: valid/ready channel carrying one result matrix
// depends on aarm_pkg
`timescale 1ns / 1ps

interface aarm_out_if;
  logic                valid;
  logic                ready;
  aarm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/aarm_cordic.sv @@
// aarm_cordic: rotation-mode cordic, one iteration per register stage
// depends on aarm_pkg; stages past the iteration count only pass data on
`timescale 1ns / 1ps

module aarm_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [aarm_pkg::Z_W-1:0]    z_i,
  output logic signed [aarm_pkg::XY_W-1:0]   x_o,
  output logic signed [aarm_pkg::XY_W-1:0]   y_o
);

  localparam int N = aarm_pkg::PIPE_STAGES;

  logic signed [aarm_pkg::XY_W-1:0] x_q [N+1];
  logic signed [aarm_pkg::XY_W-1:0] y_q [N+1];
  logic signed [aarm_pkg::Z_W-1:0]  z_q [N+1];

  assign x_q[0] = aarm_pkg::GAIN_Q30;
  assign y_q[0] = '0;
  assign z_q[0] = z_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam bit ACTIVE = (i < ITERATIONS) && (i < aarm_pkg::ATAN_COUNT);
    localparam logic signed [aarm_pkg::Z_W-1:0] ATAN =
      aarm_pkg::Z_W'(aarm_pkg::atan_turn(5'(i)));
    logic signed [aarm_pkg::XY_W-1:0] x_d, y_d;
    logic signed [aarm_pkg::Z_W-1:0]  z_d;

    always_comb begin
      x_d = x_q[i];
      y_d = y_q[i];
      z_d = z_q[i];
      if (ACTIVE) begin
        if (z_q[i] >= 0) begin
          x_d = x_q[i] - (y_q[i] >>> i);
          y_d = y_q[i] + (x_q[i] >>> i);
          z_d = z_q[i] - ATAN;
        end else begin
          x_d = x_q[i] + (y_q[i] >>> i);
          y_d = y_q[i] - (x_q[i] >>> i);
          z_d = z_q[i] + ATAN;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
        z_q[i+1] <= z_d;
      end
    end
  end

  assign x_o = x_q[N];
  assign y_o = y_q[N];

endmodule

@@ rtl/core/aarm_sqrt.sv @@
// aarm_sqrt: pipelined floor square root of n2 * 2^32, one result bit per stage
// depends on aarm_pkg
`timescale 1ns / 1ps

module aarm_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] n2_i,
  output logic [31:0] root_o
);

  localparam int N = aarm_pkg::PIPE_STAGES;

  logic [34:0] rem_q  [N+1];
  logic [31:0] root_q [N+1];
  logic [63:0] v_q    [N+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign v_q[0]    = {n2_i, 32'h0};

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [34:0] rem_n, trial;
    logic [34:0] rem_d;
    logic [31:0] root_d;

    always_comb begin
      rem_n = {rem_q[k][32:0], v_q[k][63:62]};
      trial = {1'b0, root_q[k], 2'b01};
      if (rem_n >= trial) begin
        rem_d  = rem_n - trial;
        root_d = {root_q[k][30:0], 1'b1};
      end else begin
        rem_d  = rem_n;
        root_d = {root_q[k][30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
        v_q[k+1]    <= {v_q[k][61:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[N];

endmodule

@@ rtl/core/aarm_div.sv @@
// aarm_div: pipelined signed by unsigned divide, truncating toward zero
// depends on aarm_pkg; one quotient bit per stage, quotient assumed below 2^QUO_W
`timescale 1ns / 1ps

module aarm_div (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [aarm_pkg::NUM_W-1:0]     num_i,
  input  logic        [aarm_pkg::DEN_W-1:0]     den_i,
  output logic signed [aarm_pkg::QS_W-1:0]      quo_o
);

  localparam int NW = aarm_pkg::NUM_W;
  localparam int DW = aarm_pkg::DEN_W;
  localparam int QW = aarm_pkg::QUO_W;

  logic [NW-1:0] mag_q;
  logic          neg0_q;
  logic [DW-1:0] den0_q;

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic          neg_q [QW+1];

  logic signed [aarm_pkg::QS_W-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      neg0_q <= num_i[NW-1];
      den0_q <= den_i;
    end
  end

  // top bits are below the divisor, so only the quotient bits need steps
  assign rem_q[0] = DW'(mag_q[NW-1:QW]);
  assign low_q[0] = mag_q[QW-1:0];
  assign quo_q[0] = '0;
  assign den_q[0] = den0_q;
  assign neg_q[0] = neg0_q;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0]   t;
    logic [DW-1:0] rem_d;
    logic          bit_d;

    always_comb begin
      t = {rem_q[k], low_q[k][QW-1]};
      if (t >= {1'b0, den_q[k]}) begin
        rem_d = DW'(t - {1'b0, den_q[k]});
        bit_d = 1'b1;
      end else begin
        rem_d = t[DW-1:0];
        bit_d = 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        low_q[k+1] <= {low_q[k][QW-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][QW-2:0], bit_d};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= neg_q[QW] ? -$signed({1'b0, quo_q[QW]}) : $signed({1'b0, quo_q[QW]});
    end
  end

  assign quo_o = res_q;

endmodule

@@ rtl/core/axis_angle_rotation_matrix.sv @@
// axis_angle_rotation_matrix: axis and angle to a Q2.14 rotation matrix (Rodrigues)
// depends on aarm_pkg, aarm_in_if, aarm_out_if, aarm_cordic, aarm_sqrt, aarm_div
//
//   port          dir   handshake      carries
//   in_i          in    valid/ready    axis_x, axis_y, axis_z, angle
//   out_o         out   valid/ready    m00..m22, axis_zero
//   cfg_we_i      in    write enable   cfg_wdata_i = angle_in_degrees
//
// one item per cycle while the skid register is empty; each item passes through the
// 32-stage cordic/square root pipeline and the 36-stage dividers to the output register
// rst_ni clears the valid bits, those of the output and skid registers too, and the degree bit at once
// the whole pipeline holds while the skid register is full; in_i.ready is its inverse
`timescale 1ns / 1ps

module axis_angle_rotation_matrix #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  aarm_in_if.sink    in_i,
  aarm_out_if.source out_o
);

  localparam int NS = aarm_pkg::PIPE_STAGES;
  localparam int DL = aarm_pkg::DIV_LAT;
  localparam int XW = aarm_pkg::XY_W;
  localparam int QS = aarm_pkg::QS_W;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    logic [1:0]       quad;
    logic             zero;
    logic [2:0][15:0] a;
    logic [5:0][31:0] aa;
    logic [31:0]      n2;
  } side_t;

  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] c;
  } dside_t;

  logic deg_q;
  logic en;

  // stage 1
  logic               s1_v_q;
  aarm_pkg::in_item_t s1_q;
  // stage 2
  logic                                s2_v_q;
  logic signed [aarm_pkg::PROD_W-1:0]  s2_prod_q;
  logic [2:0][15:0]                    s2_a_q;
  logic [5:0][31:0]                    s2_aa_q;
  // stage 3
  logic                             s3_v_q;
  logic signed [aarm_pkg::Z_W-1:0]  s3_z_q;
  side_t                            s3_q;
  // cordic / sqrt alignment
  logic  side_v_q [NS];
  side_t side_q   [NS];
  logic signed [XW-1:0] cx, cy;
  logic [31:0]          root;
  // stage 4
  logic                 s4_v_q;
  side_t                s4_q;
  logic signed [XW-1:0] s4_c_q, s4_s_q;
  logic signed [XW:0]   s4_q1_q;
  logic [31:0]          s4_r_q;
  // stage 5
  logic                                   s5_v_q;
  logic signed [aarm_pkg::NUM_W-1:0]      s5_num_q [9];
  logic [aarm_pkg::DEN_W-1:0]             s5_den_q [9];
  dside_t                                 s5_q;
  // divider alignment
  logic   dside_v_q [DL];
  dside_t dside_q   [DL];
  logic signed [QS-1:0] qd [9];
  // output
  aarm_pkg::out_item_t res, out_q, skid_q;
  logic                out_v_q, skid_v_q, pipe_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= 1'b0;
    end else if (cfg_we_i) begin
      deg_q <= cfg_wdata_i;
    end
  end

  assign en         = ~skid_v_q;
  assign in_i.ready = en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= side_v_q[NS-1];
      s5_v_q <= s4_v_q;
    end
  end

  // stages 1 and 2: capture, then the angle scale and axis products
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= in_i.data;
      s2_prod_q <= aarm_pkg::PROD_W'(s1_q.angle) *
                   aarm_pkg::PROD_W'(deg_q ? aarm_pkg::DEG_K : aarm_pkg::RAD_K);
      s2_a_q    <= {s1_q.axis_x, s1_q.axis_y, s1_q.axis_z};
      s2_aa_q[0] <= 32'(s1_q.axis_x) * 32'(s1_q.axis_x);
      s2_aa_q[1] <= 32'(s1_q.axis_x) * 32'(s1_q.axis_y);
      s2_aa_q[2] <= 32'(s1_q.axis_x) * 32'(s1_q.axis_z);
      s2_aa_q[3] <= 32'(s1_q.axis_y) * 32'(s1_q.axis_y);
      s2_aa_q[4] <= 32'(s1_q.axis_y) * 32'(s1_q.axis_z);
      s2_aa_q[5] <= 32'(s1_q.axis_z) * 32'(s1_q.axis_z);
    end
  end

  // stage 3: quadrant split of the binary angle, squared length
  logic [31:0] phase, rr;
  logic [1:0]  quad;
  logic [31:0] n2;
  always_comb begin
    phase = s2_prod_q[39:8];
    quad  = 2'((phase + 32'h2000_0000) >> 30);
    rr    = phase - {quad, 30'h0};
    n2    = s2_aa_q[0] + s2_aa_q[3] + s2_aa_q[5];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_z_q    <= aarm_pkg::Z_W'($signed(rr));
      s3_q.quad <= quad;
      s3_q.zero <= (n2 == 32'h0);
      s3_q.a    <= s2_a_q;
      s3_q.aa   <= s2_aa_q;
      s3_q.n2   <= n2;
    end
  end

  aarm_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .z_i   (s3_z_q),
    .x_o   (cx),
    .y_o   (cy)
  );

  aarm_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .n2_i   (s3_q.n2),
    .root_o (root)
  );

  for (genvar k = 0; k < NS; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_v_q[k] <= 1'b0;
      end else if (en) begin
        side_v_q[k] <= (k == 0) ? s3_v_q : side_v_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= (k == 0) ? s3_q : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // stage 4: quadrant turn to cos and sin
  logic signed [XW-1:0] c_d, s_d;
  always_comb begin
    case (side_q[NS-1].quad)
      QUAD_0: begin
        c_d = cx;
        s_d = cy;
      end
      QUAD_1: begin
        c_d = -cy;
        s_d = cx;
      end
      QUAD_2: begin
        c_d = -cx;
        s_d = -cy;
      end
      default: begin
        c_d = cy;
        s_d = -cx;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q    <= side_q[NS-1];
      s4_c_q  <= c_d;
      s4_s_q  <= s_d;
      s4_q1_q <= (XW+1)'(aarm_pkg::ONE_Q30) - (XW+1)'(c_d);
      s4_r_q  <= root;
    end
  end

  // stage 5: numerators for the nine divides
  logic signed [66:0] pm [6];
  logic signed [49:0] ps [3];
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pm[k] = 67'($signed(s4_q.aa[k])) * 67'(s4_q1_q);
    end
    for (int k = 0; k < 3; k++) begin
      ps[k] = 50'($signed(s4_q.a[2-k])) * 50'(s4_s_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        s5_num_q[k] <= pm[k][63:0];
        s5_den_q[k] <= s4_q.n2;
      end
      // lanes 6..8 hold a_x, a_y, a_z times s, scaled by 2^16
      for (int k = 0; k < 3; k++) begin
        s5_num_q[6+k] <= {ps[k][47:0], 16'h0};
        s5_den_q[6+k] <= s4_r_q;
      end
      s5_q.zero <= s4_q.zero;
      s5_q.c    <= s4_c_q;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_div
    aarm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s5_num_q[k]),
      .den_i (s5_den_q[k]),
      .quo_o (qd[k])
    );
  end

  for (genvar k = 0; k < DL; k++) begin : g_dside
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dside_v_q[k] <= 1'b0;
      end else if (en) begin
        dside_v_q[k] <= (k == 0) ? s5_v_q : dside_v_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dside_q[k] <= (k == 0) ? s5_q : dside_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
    logic signed [36:0] t;
    logic signed [20:0] sh;
    logic signed [15:0] r;
    t  = 37'(v) + 37'sd32768;
    sh = 21'(t >>> 16);
    if (sh > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (sh < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = sh[15:0];
    end
    return r;
  endfunction

  // final combine: diagonal adds c, off diagonal adds or subtracts the sine terms; a zero axis gives the identity
  logic signed [XW-1:0] cf;
  assign cf     = dside_q[DL-1].c;
  assign pipe_v = dside_v_q[DL-1];

  always_comb begin
    if (dside_q[DL-1].zero) begin
      res.m00 = aarm_pkg::ONE_Q14;
      res.m01 = '0;
      res.m02 = '0;
      res.m10 = '0;
      res.m11 = aarm_pkg::ONE_Q14;
      res.m12 = '0;
      res.m20 = '0;
      res.m21 = '0;
      res.m22 = aarm_pkg::ONE_Q14;
      res.axis_zero = 1'b1;
    end else begin
      res.m00 = to_q14(36'(qd[0]) + 36'(cf));
      res.m01 = to_q14(36'(qd[1]) - 36'(qd[8]));
      res.m02 = to_q14(36'(qd[2]) + 36'(qd[7]));
      res.m10 = to_q14(36'(qd[1]) + 36'(qd[8]));
      res.m11 = to_q14(36'(qd[3]) + 36'(cf));
      res.m12 = to_q14(36'(qd[4]) - 36'(qd[6]));
      res.m20 = to_q14(36'(qd[2]) - 36'(qd[7]));
      res.m21 = to_q14(36'(qd[4]) + 36'(qd[6]));
      res.m22 = to_q14(36'(qd[5]) + 36'(cf));
      res.axis_zero = 1'b0;
    end
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      out_v_q  <= skid_v_q | pipe_v;
      skid_v_q <= 1'b0;
    end else if (pipe_v && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_o.ready) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (pipe_v && en) begin
      skid_q <= res;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds an item while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_o.ready) |=> skid_v_q)
    else $error("skid item dropped without the output being taken");

  a_zero_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.axis_zero) |->
      (out_q.m00 == aarm_pkg::ONE_Q14 && out_q.m11 == aarm_pkg::ONE_Q14 &&
       out_q.m22 == aarm_pkg::ONE_Q14 && out_q.m01 == 16'sd0))
    else $error("zero axis item without identity matrix");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_o.ready && !skid_v_q && !pipe_v) |=> !out_v_q)
    else $error("output valid without a source item");

endmodule

@@ bench/aarm_rotation_checker.sv @@
// aarm_rotation_checker: watches both channels, predicts each rotation matrix, compares
// depends on aarm_pkg, aarm_in_if, aarm_out_if
`timescale 1ns / 1ps

module aarm_rotation_checker #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  aarm_in_if         in_mon,
  aarm_out_if        out_mon,
  output int         fail_count,
  output int         pending_count,
  output int         matrix_count,
  output int         zero_axis_count
);

  aarm_pkg::out_item_t expected_matrices[$];
  logic                degrees_mode;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [15:0] round_q14(longint v30);
    longint v;
    v = floor_shr(v30 + (64'sd1 <<< 15), 16);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic aarm_pkg::out_item_t rotation_matrix(aarm_pkg::in_item_t it, logic deg);
    aarm_pkg::out_item_t res;
    longint a[3], c, s, q1, n2, r, m[9], sk[3], k, x, y, z, dx, dy;
    logic [31:0] phase, quad, rr;
    longint prod;
    a[0] = it.axis_x;
    a[1] = it.axis_y;
    a[2] = it.axis_z;
    n2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    if (n2 == 0) begin
      res = '0;
      res.m00 = aarm_pkg::ONE_Q14;
      res.m11 = aarm_pkg::ONE_Q14;
      res.m22 = aarm_pkg::ONE_Q14;
      res.axis_zero = 1'b1;
      return res;
    end
    k = deg ? longint'(aarm_pkg::DEG_K) : longint'(aarm_pkg::RAD_K);
    prod = longint'(it.angle) * k;
    phase = prod[39:8];
    quad = (phase + 32'h20000000) >> 30;
    rr = phase - (quad << 30);
    z = longint'($signed(rr));
    x = aarm_pkg::GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_ITERATIONS && i < aarm_pkg::ATAN_COUNT; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(aarm_pkg::atan_turn(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(aarm_pkg::atan_turn(i[4:0]));
      end
    end
    case (quad[1:0])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    q1 = (64'sd1 <<< 30) - c;
    r = int_sqrt(longint'(n2) << 32);
    for (int i = 0; i < 3; i++) sk[i] = (a[i] * s * 65536) / r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i*3+j] = (a[i] * a[j] * q1) / n2;
    m[0] += c; m[4] += c; m[8] += c;
    m[1] -= sk[2]; m[2] += sk[1]; m[3] += sk[2];
    m[5] -= sk[0]; m[6] -= sk[1]; m[7] += sk[0];
    res.m00 = round_q14(m[0]); res.m01 = round_q14(m[1]); res.m02 = round_q14(m[2]);
    res.m10 = round_q14(m[3]); res.m11 = round_q14(m[4]); res.m12 = round_q14(m[5]);
    res.m20 = round_q14(m[6]); res.m21 = round_q14(m[7]); res.m22 = round_q14(m[8]);
    res.axis_zero = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    aarm_pkg::out_item_t want;
    aarm_pkg::out_item_t got;
    if (!rst_ni) begin
      degrees_mode <= 1'b0;
      fail_count = 0;
      matrix_count = 0;
      zero_axis_count = 0;
      expected_matrices.delete();
      pending_count = 0;
    end else begin
      // prediction uses the setting in force before this edge's write
      if (in_mon.valid && in_mon.ready)
        expected_matrices.push_back(rotation_matrix(in_mon.data, degrees_mode));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_matrices.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected matrix %h", got);
        end else begin
          want = expected_matrices.pop_front();
          matrix_count++;
          if (got.axis_zero) zero_axis_count++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("matrix %0d mismatch: exp %p got %p", matrix_count, want, got);
          end
        end
      end
      pending_count = expected_matrices.size();
      if (cfg_we_i) degrees_mode <= cfg_wdata_i;
    end
  end
endmodule

@@ bench/axis_angle_rotation_matrix_test.sv @@
// axis_angle_rotation_matrix_test: stimulus, stalls and verdict for the rotation block
// depends on aarm_pkg, aarm_in_if, aarm_out_if, aarm_rotation_checker, the block
`timescale 1ns / 1ps

module axis_angle_rotation_matrix_test;

  localparam int LATENCY = 73;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic long_hold = 1'b0;
  logic stim_done = 1'b0;
  int   fail_count, pending_count, matrix_count, zero_axis_count;

  aarm_in_if  in_ch();
  aarm_out_if out_ch();

  axis_angle_rotation_matrix u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_ch), .out_o(out_ch)
  );

  aarm_rotation_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_mon(in_ch), .out_mon(out_ch), .fail_count(fail_count),
    .pending_count(pending_count), .matrix_count(matrix_count),
    .zero_axis_count(zero_axis_count)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic signed [15:0] pick_component();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // valid stays high after an item so that items can follow with no gap
  task automatic send_rotation(input logic signed [15:0] ax, ay, az, ang, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{axis_x: ax, axis_y: ay, axis_z: az, angle: ang};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_and_set(input logic deg);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= deg;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random stalls on the result side, with one long hold-off
  initial begin
    int stall;
    @(posedge rst_ni);
    while (1) begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
      end else begin
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
        while (!out_ch.valid) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic signed [15:0] ang_list[8];
    ang_list = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sd6434, -16'sd6434,
                 16'sd5760, 16'sd11520, 16'sd1};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // radians, directed extremes
    send_rotation(0, 0, 0, 16'sd1000, 0);
    send_rotation(0, 0, 0, 16'sh8000, 0);
    foreach (ang_list[i]) send_rotation(16'sd1, 0, 0, ang_list[i], 0);
    send_rotation(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd3217, 0);
    send_rotation(16'sh8000, 16'sh8000, 16'sh8000, -16'sd3217, 0);
    send_rotation(0, 16'sh8000, 0, 16'sh7fff, 0);
    send_rotation(0, 0, 16'sh7fff, 16'sh8000, 0);
    send_rotation(-16'sd1, 16'sd1, 16'sd1, 16'sd12868, 0);
    drain_and_set(1'b1);
    foreach (ang_list[i]) send_rotation(0, 0, 16'sd5, ang_list[i], 0);
    send_rotation(16'sh8000, 16'sh7fff, 0, 16'sh8000, 0);
    // long receiver hold while the sender keeps pushing
    long_hold = 1'b1;
    fork
      begin repeat (300) @(negedge clk_i); long_hold = 1'b0; end
      for (int i = 0; i < 150; i++)
        send_rotation(pick_component(), pick_component(), pick_component(),
                      16'($urandom), 1);
    join
    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      drain_and_set(phase_no[0]);
      for (int i = 0; i < 300; i++)
        send_rotation(pick_component(), pick_component(), pick_component(),
                      16'($urandom), ($urandom_range(0, 3) == 0));
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending_count != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("covered %0d matrices (%0d with zero axis) in both angle units",
             matrix_count, zero_axis_count);
    if (fail_count == 0) begin
      $display("PASS axis_angle_rotation_matrix");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL axis_angle_rotation_matrix");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("FAIL axis_angle_rotation_matrix");
    $finish;
  end
endmodule

@@ axis_angle_rotation_matrix.f @@
rtl/core/aarm_pkg.sv
rtl/core/aarm_in_if.sv
rtl/core/aarm_out_if.sv
rtl/core/aarm_cordic.sv
rtl/core/aarm_sqrt.sv
rtl/core/aarm_div.sv
rtl/core/axis_angle_rotation_matrix.sv
bench/aarm_rotation_checker.sv
bench/axis_angle_rotation_matrix_test.sv
